>>> sv/drld_pkg.sv
// shared types and constants of the data run list decoder
package drld_pkg;

  // one beat of the byte input
  typedef struct packed {
    logic [7:0] run_byte;
  } run_beat_t;

  // one decoded result beat
  typedef struct packed {
    logic [63:0]        cluster_count;
    logic signed [63:0] relative_offset;
    logic               sparse_run;
    logic               list_end;
    logic               malformed;
  } frag_beat_t;

  // work handed from the front to the back
  typedef enum logic [2:0] {
    OP_END,
    OP_BAD,
    OP_CLEAR,
    OP_LEN,
    OP_OFF
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic [2:0] pos;
    logic [3:0] width;
    logic       emit;
    logic       sparse;
  } op_t;

  localparam logic [7:0] HDR_END    = 8'h00;
  localparam logic [3:0] NIBBLE_MSK = 4'hF;
  localparam int unsigned NIBBLE_W  = 4;

endpackage

>>> sv/drld_stream_if.sv
// valid/ready channel carrying one payload beat
interface drld_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/drld_front.sv
// front end: tracks the run list phase and classifies each byte
module drld_front import drld_pkg::*; #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       full_i,
  output logic       ready_o,
  output logic       push_o,
  output op_t        op_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] len_left_q, len_left_d;
  logic [3:0] off_left_q, off_left_d;
  logic [3:0] width_q, width_d;
  logic [2:0] pos_q, pos_d;
  logic       fire;
  logic [3:0] lo, hi;
  logic [3:0] max_nib;

  assign ready_o = !full_i;
  assign fire    = valid_i && !full_i;
  assign push_o  = fire;
  assign lo      = byte_i[NIBBLE_W-1:0] & NIBBLE_MSK;
  assign hi      = byte_i[7:NIBBLE_W] & NIBBLE_MSK;
  assign max_nib = 4'(MAX_FIELD_BYTES);

  always_comb begin
    phase_d    = phase_q;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    width_d    = width_q;
    pos_d      = pos_q;
    op_o       = '{kind: OP_END, data: byte_i, pos: pos_q, width: width_q,
                   emit: 1'b0, sparse: 1'b0};
    if (fire) begin
      case (phase_q)
        PH_LENGTH: begin
          op_o.kind  = OP_LEN;
          pos_d      = pos_q + 3'd1;
          len_left_d = len_left_q - 4'd1;
          if (len_left_d == 4'd0) begin
            if (off_left_q == 4'd0) begin
              op_o.emit   = 1'b1;
              op_o.sparse = 1'b1;
              phase_d     = PH_HEADER;
            end else begin
              phase_d = PH_OFFSET;
              pos_d   = 3'd0;
            end
          end
        end
        PH_OFFSET: begin
          op_o.kind  = OP_OFF;
          pos_d      = pos_q + 3'd1;
          off_left_d = off_left_q - 4'd1;
          if (off_left_d == 4'd0) begin
            op_o.emit = 1'b1;
            phase_d   = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          if (byte_i == HDR_END) begin
            op_o.kind = OP_END;
            op_o.emit = 1'b1;
          end else if (lo > max_nib || hi > max_nib) begin
            op_o.kind   = OP_BAD;
            op_o.emit   = 1'b1;
            op_o.sparse = (hi == 4'd0);
          end else begin
            op_o.kind  = OP_CLEAR;
            op_o.width = hi;
            len_left_d = lo;
            off_left_d = hi;
            width_d    = hi;
            pos_d      = 3'd0;
            phase_d    = (lo != 4'd0) ? PH_LENGTH : PH_OFFSET;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      len_left_q <= 4'd0;
      off_left_q <= 4'd0;
      width_q    <= 4'd0;
      pos_q      <= 3'd0;
    end else begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      width_q    <= width_d;
      pos_q      <= pos_d;
    end
  end

  // between runs no field bytes are outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> len_left_q == 4'd0 && off_left_q == 4'd0)
    else $error("field bytes outstanding while waiting for a header");

  // offset bytes are only gathered for a run with a nonzero offset width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_OFFSET |-> width_q != 4'd0 && off_left_q != 4'd0)
    else $error("offset phase without offset bytes");

endmodule

>>> sv/drld_queue.sv
// two-entry queue of classified bytes between front and back
module drld_queue import drld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output op_t  op_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 && !(pop_i && count_q == 2'd0) && !(push_i && full_o))
    else $error("queue overrun or underrun");

endmodule

>>> sv/drld_back.sv
// back end: gathers length and offset fields and holds the result beat
module drld_back import drld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  op_t        op_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output frag_beat_t out_data_o
);

  logic [63:0] len_q, len_d;
  logic [63:0] off_q, off_d;
  logic        out_valid_q;
  frag_beat_t  out_data_q, res;
  logic        fire;
  logic [63:0] lane;

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] w);
    logic [5:0]  top;
    logic [6:0]  sh;
    logic [63:0] r;
    top = {3'(w[2:0] - 3'd1), 3'b111};
    sh  = {w, 3'b000};
    r   = v;
    if (w < 4'd8 && v[top]) begin
      r = v | (~64'd0 << sh);
    end
    return r;
  endfunction

  assign fire = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire;
  assign lane = 64'(op_i.data) << {op_i.pos, 3'b000};

  always_comb begin
    len_d = len_q;
    off_d = off_q;
    res   = '{cluster_count: 64'd0, relative_offset: 64'sd0, sparse_run: 1'b0,
              list_end: 1'b0, malformed: 1'b0};
    case (op_i.kind)
      OP_END: begin
        res.list_end = 1'b1;
      end
      OP_BAD: begin
        res.malformed  = 1'b1;
        res.sparse_run = op_i.sparse;
      end
      OP_CLEAR: begin
        len_d = 64'd0;
        off_d = 64'd0;
      end
      OP_LEN: begin
        len_d              = len_q | lane;
        res.cluster_count  = len_d;
        res.sparse_run     = 1'b1;
      end
      OP_OFF: begin
        off_d               = off_q | lane;
        res.cluster_count   = len_q;
        res.relative_offset = sext(off_d, op_i.width);
      end
      default: begin
        len_d = len_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 64'd0;
      off_q       <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        len_q       <= len_d;
        off_q       <= off_d;
        out_valid_q <= op_i.emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && op_i.emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // end-of-list and malformed beats never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_data_q.list_end, out_data_q.malformed}))
    else $error("list end and malformed both set");

  // a sparse run never carries an offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.sparse_run |-> out_data_q.relative_offset == 64'sd0)
    else $error("sparse run with nonzero offset");

endmodule

>>> sv/data_run_list_decoder.sv
// top level of the data run list decoder
// Decodes a run list fed one byte per beat on byte_i. A header byte's low
// nibble gives the number of little-endian run-length bytes and its high
// nibble the number of offset bytes; one fragment beat leaves on frag_o
// after the last byte of each run, with the offset sign-extended from its
// byte width and sparse_run set when there are no offset bytes. A zero
// header gives an end-of-list beat, and a header with a nibble above
// MAX_FIELD_BYTES gives a malformed beat at once and is followed by a new
// header. One byte is taken every cycle while the queue is not full: the front
// classifies the byte in the cycle it is accepted, a two-entry queue hands it
// to the back, and the back folds it into the length or offset accumulator
// and registers the result beat. A fragment thus passes the queue and then the
// back's output register after the byte that completes it, and bytes keep flowing
// while a result waits for frag_o to take it, until the queue holds two bytes.
module data_run_list_decoder import drld_pkg::*; #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  drld_stream_if.sink   byte_i,
  drld_stream_if.source frag_o
);

  // front to queue
  logic push;
  op_t  op_push;
  logic full;

  // queue to back
  logic q_valid;
  op_t  op_pop;
  logic pop;

  drld_front #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .byte_i  (byte_i.data.run_byte),
    .full_i  (full),
    .ready_o (byte_i.ready),
    .push_o  (push),
    .op_o    (op_push)
  );

  // decouples byte intake from result delivery
  drld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_push),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .op_o    (op_pop)
  );

  // accumulators and the output register
  drld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .op_i        (op_pop),
    .pop_o       (pop),
    .out_valid_o (frag_o.valid),
    .out_ready_i (frag_o.ready),
    .out_data_o  (frag_o.data)
  );

endmodule

>>> verif/data_run_list_decoder_tb.sv
// self-checking testbench for the data run list decoder
`timescale 1ns / 1ps

module data_run_list_decoder_tb;
  import drld_pkg::*;

  // cycles with no beat accepted on either side before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 4000;
  // receiver hold-off used to back the block up onto its byte input
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_SHOWN   = 10;

  // parse phases of the run list decoder
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } run_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  drld_stream_if #(.T(run_beat_t))  byte_if ();
  drld_stream_if #(.T(frag_beat_t)) frag_if ();

  data_run_list_decoder #(
    .MAX_FIELD_BYTES(8)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if.sink),
    .frag_o(frag_if.source)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // decoder state mirrored by the testbench, at its reset values
  // ---------------------------------------------------------------------------
  run_phase_e  rl_phase  = PH_HEADER;
  logic [3:0]  len_left  = '0;
  logic [3:0]  off_left  = '0;
  logic [3:0]  off_width = '0;
  logic [2:0]  byte_pos  = '0;
  logic [63:0] len_acc   = '0;
  logic [63:0] off_acc   = '0;

  logic [7:0]  run_q[$];       // bytes waiting to be offered on byte_i
  frag_beat_t  frag_exp_q[$];  // fragments still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned bytes_queued  = 0;
  logic        byte_taken;

  // closing fragment of a run: the offset is sign-extended from its byte width,
  // a run without offset bytes is sparse and carries offset zero
  function automatic frag_beat_t close_run();
    frag_beat_t f;
    logic [63:0] off;
    f   = '0;
    off = '0;
    if (off_width != 0) begin
      off = off_acc;
      // a full eight-byte offset already has its sign in bit 63
      if (off_width < 8 && off[8 * off_width - 1])
        off |= ~64'd0 << (8 * off_width);
    end
    f.cluster_count   = len_acc;
    f.relative_offset = off;
    f.sparse_run      = (off_width == 0);
    rl_phase = PH_HEADER;
    return f;
  endfunction

  // folds one accepted byte into the mirrored state, returns 1 when it
  // completes a result, which is then left in frag
  function automatic bit decode_run_byte(input logic [7:0] b, output frag_beat_t frag);
    logic [3:0] lo;
    logic [3:0] hi;
    frag = '0;
    lo   = b[3:0] & NIBBLE_MSK;
    hi   = b[7:NIBBLE_W] & NIBBLE_MSK;
    case (rl_phase)
      PH_LENGTH: begin
        len_acc  |= 64'(b) << (8 * byte_pos);
        byte_pos += 3'd1;
        len_left -= 4'd1;
        if (len_left != 0) return 1'b0;
        if (off_left == 0) begin
          frag = close_run();
          return 1'b1;
        end
        rl_phase = PH_OFFSET;
        byte_pos = '0;
        return 1'b0;
      end
      PH_OFFSET: begin
        off_acc  |= 64'(b) << (8 * byte_pos);
        byte_pos += 3'd1;
        off_left -= 4'd1;
        if (off_left != 0) return 1'b0;
        frag = close_run();
        return 1'b1;
      end
      default: begin
        rl_phase = PH_HEADER;
        if (b == HDR_END) begin
          frag.list_end = 1'b1;
          return 1'b1;
        end
        // oversized nibble: flagged at once, the next byte is a header again
        if (lo > 8 || hi > 8) begin
          frag.malformed  = 1'b1;
          frag.sparse_run = (hi == 0);
          return 1'b1;
        end
        len_acc   = '0;
        off_acc   = '0;
        byte_pos  = '0;
        len_left  = lo;
        off_left  = hi;
        off_width = hi;
        // zero length bytes go straight to the offset field
        rl_phase  = (lo != 0) ? PH_LENGTH : PH_OFFSET;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input frag_beat_t want,
                               input frag_beat_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t %s: expected count %0h off %0d sparse %0b end %0b bad %0b, got count %0h off %0d sparse %0b end %0b bad %0b",
               $realtime, what, want.cluster_count, want.relative_offset, want.sparse_run,
               want.list_end, want.malformed, got.cluster_count, got.relative_offset,
               got.sparse_run, got.list_end, got.malformed);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: a new beat goes up at the falling edge once the last one was
  // taken, or whenever the line is idle
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_taken) begin
      if (run_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_if.valid         <= 1'b1;
        byte_if.data.run_byte <= run_q.pop_front();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // fragment receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      frag_if.ready <= 1'b0;
    end else begin
      frag_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted byte beat, checks every fragment beat
  // against the oldest expectation, and keeps the hang watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    frag_beat_t want;
    frag_beat_t got;
    if (!rst_ni) begin
      byte_taken   <= 1'b0;
      quiet_cycles = 0;
    end else begin
      byte_taken <= byte_if.valid && byte_if.ready;
      if (byte_if.valid && byte_if.ready) begin
        if (decode_run_byte(byte_if.data.run_byte, want))
          frag_exp_q = {frag_exp_q, want};
      end
      if (frag_if.valid && frag_if.ready) begin
        got = frag_if.data;
        if (frag_exp_q.size() == 0) begin
          note_mismatch("fragment with none expected", '0, got);
        end else begin
          want = frag_exp_q.pop_front();
          if (got.cluster_count !== want.cluster_count ||
              got.relative_offset !== want.relative_offset ||
              got.sparse_run !== want.sparse_run ||
              got.list_end !== want.list_end ||
              got.malformed !== want.malformed)
            note_mismatch("fragment mismatch", want, got);
        end
      end
      if ((byte_if.valid && byte_if.ready) || (frag_if.valid && frag_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t watchdog: no beat accepted for %0d cycles", $realtime, quiet_cycles);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    run_q = {run_q, b};
    bytes_queued++;
  endtask

  // one chunk of run list: mostly well-formed runs with random content, the
  // rest end markers, oversized headers and stray bytes that break the framing
  task automatic send_random_run();
    int unsigned pick;
    logic [3:0] lo;
    logic [3:0] hi;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_byte(HDR_END);
    end else if (pick < 16) begin
      lo = 4'($urandom_range(15));
      hi = 4'($urandom_range(9, 15));
      if ($urandom_range(1)) send_byte({hi, lo});
      else send_byte({lo, hi});
    end else if (pick < 20) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      lo = 4'($urandom_range(8));
      hi = 4'($urandom_range(8));
      if (lo == 0 && hi == 0) lo = 4'd1;
      send_byte({hi, lo});
      repeat (int'(lo) + int'(hi)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // sender holds back until every byte is out and every fragment is back
  task automatic wait_drained();
    while (run_q.size() != 0 || byte_if.valid || frag_exp_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input int unsigned n_bytes);
    int unsigned stop_at;
    @(posedge clk_i);
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) send_random_run();
    wait_drained();
  endtask

  initial begin
    byte_if.valid = 1'b0;
    byte_if.data  = '0;
    frag_if.ready = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed runs, no idling on either side
    send_byte(HDR_END);                       // end of list
    send_byte(8'h09);                         // low nibble oversized, sparse flag set
    send_byte(8'h90);                         // high nibble oversized
    send_byte(8'hFF);                         // both nibbles oversized
    send_byte(8'h11); send_byte(8'h05); send_byte(8'h80);  // one-byte negative offset
    send_byte(8'h01); send_byte(8'hFF);       // sparse run
    send_byte(8'h10); send_byte(8'h7F);       // zero length bytes, positive offset
    // full-width length and offset, offset top bit set
    send_byte(8'h88);
    repeat (8) send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h23); send_byte(8'h45); send_byte(8'h67);
    send_byte(8'h89); send_byte(8'hAB); send_byte(8'hCD); send_byte(8'hEF);
    wait_drained();

    random_phase(0, 0, 450);
    random_phase(86, 0, 350);
    random_phase(0, 86, 350);
    random_phase(23, 23, 450);

    // receiver holds off while bytes keep coming, so the block backs up
    @(posedge clk_i);
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (30) send_random_run();
    hold_left = HOLD_CYCLES;
    wait_drained();

    random_phase(0, 0, 300);

    // quiet tail so that a stray fragment would still be seen
    @(posedge clk_i);
    stall_pct = 0;
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/drld_pkg.sv
sv/drld_stream_if.sv
sv/drld_front.sv
sv/drld_queue.sv
sv/drld_back.sv
sv/data_run_list_decoder.sv
verif/data_run_list_decoder_tb.sv
